/* rtl/core/ncl_pkg.sv */
`timescale 1ns / 1ps

package ncl_pkg;

  localparam int unsigned DIST_W  = 10;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } req_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] match_index;
    logic [7:0]         match_red;
    logic [7:0]         match_green;
    logic [7:0]         match_blue;
    logic [DIST_W-1:0]  distance;
    logic [COUNT_W-1:0] entry_count;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic start;
    logic valid;
  } scan_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

/* rtl/core/ncl_ram.sv */
`timescale 1ns / 1ps

module ncl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ncl_dist_unit.sv */
`timescale 1ns / 1ps

module ncl_dist_unit #(
  parameter int unsigned AW = 10
) (
  input  logic                       clk,
  input  ncl_pkg::scan_ctl_t         ctl,
  input  ncl_pkg::rgb_t              query,
  input  ncl_pkg::rgb_t              entry,
  input  logic [AW-1:0]              index,
  output logic [AW-1:0]              best_index,
  output ncl_pkg::rgb_t              best_color,
  output logic [ncl_pkg::DIST_W-1:0] best_dist
);

  logic [7:0]                 diff_r;
  logic [7:0]                 diff_g;
  logic [7:0]                 diff_b;
  logic [ncl_pkg::DIST_W-1:0] cur_dist;
  logic                       best_valid;
  logic                       take;

  always_comb begin
    diff_r = (query.red >= entry.red) ? query.red - entry.red : entry.red - query.red;
    diff_g = (query.green >= entry.green) ? query.green - entry.green
                                          : entry.green - query.green;
    diff_b = (query.blue >= entry.blue) ? query.blue - entry.blue : entry.blue - query.blue;
    cur_dist = ncl_pkg::DIST_W'(diff_r) + ncl_pkg::DIST_W'(diff_g)
             + ncl_pkg::DIST_W'(diff_b);
    // strict compare keeps the first of equal entries
    take   = ctl.valid && (!best_valid || (cur_dist < best_dist));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best_valid <= 1'b0;
    end else if (take) begin
      best_valid <= 1'b1;
    end
    if (take) begin
      best_index <= index;
      best_color <= entry;
      best_dist  <= cur_dist;
    end
  end

endmodule

/* rtl/core/nearest_color_l1_search_top.sv */
// append, clear and empty query go from idle to finish, which registers the result
// once the output is free; a query over stored entries first runs scan and drain
// requests stall outside idle, so items are taken one at a time; a query reads the
// palette one entry per cycle through the single distance/compare unit
// reset clears the entry count and both handshakes; palette contents stay undefined
// and no clearing pass is run
`timescale 1ns / 1ps

module nearest_color_l1_search_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ncl_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ncl_pkg::rsp_item_t rsp
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  ncl_pkg::state_t            state;
  ncl_pkg::state_t            state_next;
  logic [CW-1:0]              count;
  logic [AW-1:0]              scan_addr;
  logic [AW-1:0]              rd_index;
  logic                       rd_pending;
  logic                       ram_re;
  logic                       ram_we;
  logic                       accept;
  logic                       full;
  logic                       last;
  logic                       rsp_free;
  logic                       finish_go;
  logic                       is_query;
  ncl_pkg::rgb_t              q_color;
  ncl_pkg::rgb_t              req_color;
  ncl_pkg::rgb_t              rd_color;
  ncl_pkg::scan_ctl_t         ctl;
  ncl_pkg::rsp_item_t         res;
  ncl_pkg::rsp_item_t         res_next;
  logic [AW-1:0]              best_index;
  ncl_pkg::rgb_t              best_color;
  logic [ncl_pkg::DIST_W-1:0] best_dist;

  assign req_color = '{red: req.red, green: req.green, blue: req.blue};
  assign full      = (count == CW'(TABLE_DEPTH));
  assign last      = ((CW'(scan_addr) + CW'(1)) == count);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign accept    = req_valid && (state == ncl_pkg::S_IDLE);
  assign req_stall = (state != ncl_pkg::S_IDLE);
  assign finish_go = (state == ncl_pkg::S_FINISH) && rsp_free;
  assign ram_we    = accept && (req.kind == ncl_pkg::KIND_APPEND) && !full;

  ncl_ram #(
    .WIDTH ($bits(ncl_pkg::rgb_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count)),
    .wdata (req_color),
    .re    (ram_re),
    .raddr (scan_addr),
    .rdata (rd_color)
  );

  ncl_dist_unit #(
    .AW (AW)
  ) u_dist (
    .clk        (clk),
    .ctl        (ctl),
    .query      (q_color),
    .entry      (rd_color),
    .index      (rd_index),
    .best_index (best_index),
    .best_color (best_color),
    .best_dist  (best_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ctl.start  = 1'b0;
    ctl.valid  = rd_pending;
    unique case (state)
      ncl_pkg::S_IDLE: begin
        if (req_valid) begin
          if ((req.kind == ncl_pkg::KIND_QUERY) && (count != '0)) begin
            state_next = ncl_pkg::S_SCAN;
            ctl.start  = 1'b1;
          end else begin
            state_next = ncl_pkg::S_FINISH;
          end
        end
      end
      ncl_pkg::S_SCAN: begin
        ram_re = 1'b1;
        if (last) begin
          state_next = ncl_pkg::S_DRAIN;
        end
      end
      ncl_pkg::S_DRAIN: begin
        state_next = ncl_pkg::S_FINISH;
      end
      ncl_pkg::S_FINISH: begin
        if (rsp_free) begin
          state_next = ncl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ncl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_next             = '0;
    res_next.status      = ncl_pkg::STATUS_OK;
    res_next.entry_count = ncl_pkg::COUNT_W'(count);
    case (req.kind)
      ncl_pkg::KIND_APPEND: begin
        if (full) begin
          res_next.status = ncl_pkg::STATUS_FULL;
        end else begin
          res_next.match_index = ncl_pkg::INDEX_W'(count);
          res_next.match_red   = req.red;
          res_next.match_green = req.green;
          res_next.match_blue  = req.blue;
          res_next.entry_count = ncl_pkg::COUNT_W'(count + CW'(1));
        end
      end
      ncl_pkg::KIND_QUERY: begin
        if (count == '0) begin
          res_next.status = ncl_pkg::STATUS_EMPTY;
        end
      end
      ncl_pkg::KIND_CLEAR: begin
        res_next.entry_count = '0;
      end
      default: begin
        res_next.entry_count = ncl_pkg::COUNT_W'(count);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_pending <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_pending <= ram_re;
      if (accept) begin
        case (req.kind)
          ncl_pkg::KIND_APPEND: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          ncl_pkg::KIND_CLEAR: begin
            count <= '0;
          end
          default: begin
            count <= count;
          end
        endcase
      end
      if (finish_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_index <= scan_addr;
    if (accept) begin
      q_color   <= req_color;
      is_query  <= (req.kind == ncl_pkg::KIND_QUERY) && (count != '0);
      res       <= res_next;
      scan_addr <= '0;
    end else if (ram_re) begin
      scan_addr <= scan_addr + AW'(1);
    end
    if (finish_go) begin
      if (is_query) begin
        rsp.status      <= ncl_pkg::STATUS_OK;
        rsp.match_index <= ncl_pkg::INDEX_W'(best_index);
        rsp.match_red   <= best_color.red;
        rsp.match_green <= best_color.green;
        rsp.match_blue  <= best_color.blue;
        rsp.distance    <= best_dist;
        rsp.entry_count <= ncl_pkg::COUNT_W'(count);
      end else begin
        rsp <= res;
      end
    end
  end

endmodule

/* rtl/core/ncl_checker.sv */
`timescale 1ns / 1ps

module ncl_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input ncl_pkg::rsp_item_t rsp
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("item accepted while previous one still in progress");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ncl_pkg::STATUS_EMPTY)) |-> (rsp.entry_count == '0))
    else $error("empty status with nonzero entry count");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ncl_pkg::STATUS_OK))
      |-> ((rsp.distance == '0) && (rsp.match_index == '0)))
    else $error("error result carries match data");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.distance <= ncl_pkg::DIST_W'(765)))
    else $error("distance out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind nearest_color_l1_search_top ncl_checker u_ncl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
